### rtl/vbap_pair_gain_search_defines.svh
// Assertion macros shared by the RTL of the pair gain search block.
// Depends on nothing; files that check their own logic include it.
// Each macro has an active form and an empty form for synthesis builds.
`ifndef VBAP_PAIR_GAIN_SEARCH_DEFINES_SVH
`define VBAP_PAIR_GAIN_SEARCH_DEFINES_SVH
`ifndef SYNTH
// Same-cycle implication, disabled while reset is asserted.
`define VBPS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, disabled while reset is asserted.
`define VBPS_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define VBPS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define VBPS_ASSERT_NXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

### rtl/vbps_pkg.sv
// Package of the pair gain search block: widths, polynomial constants,
// state and opcode types, and control structs. Depends on nothing.
`default_nettype none
package vbps_pkg;

    localparam int MAX_PAIRS_DEF   = 32;
    localparam int COEF_WIDTH_DEF  = 16;
    localparam int ANGLE_WIDTH_DEF = 16;

    localparam int INDEX_W    = 5;
    localparam int RAW_COEF_W = 16;
    localparam int SPK_W      = 5;
    localparam int AZ_W       = 16;
    localparam int PCNT_W     = 6;
    localparam int GAIN_W     = 16;
    localparam int Q15_W      = 17;
    localparam int XY_W       = 18;
    localparam int QUOT_W     = 17;
    localparam int S_TDATA_W  = 96;
    localparam int M_TDATA_W  = 48;
    localparam int EVAL_DEPTH = 4;
    localparam int NEG_TOL    = 134;

    localparam logic [Q15_W-1:0] POLY_A  = 17'd51472;
    localparam logic [Q15_W-1:0] POLY_B  = 17'd21024;
    localparam logic [Q15_W-1:0] POLY_C  = 17'd2320;
    localparam logic [Q15_W-1:0] ONE_Q15 = 17'd32768;

    typedef enum logic {
        OP_LOAD  = 1'b0,
        OP_QUERY = 1'b1
    } t_op;

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_SINE  = 6'b000010,
        ST_SCAN  = 6'b000100,
        ST_DRAIN = 6'b001000,
        ST_NORM  = 6'b010000,
        ST_FIN   = 6'b100000
    } t_state;

    typedef struct packed {
        logic load;
        logic shift;
    } t_cell_ctl;

    typedef struct packed {
        logic clear;
        logic valid;
    } t_eval_ctl;

endpackage
`default_nettype wire

### rtl/vbps_cell.sv
// One cell of the pair table ring: holds one pair entry, takes a load
// aimed at its slot, and passes its entry to its neighbor while scanning.
// Depends on vbps_pkg.
`default_nettype none
module vbps_cell
    import vbps_pkg::*;
#(
    parameter int COEF_WIDTH = COEF_WIDTH_DEF,
    parameter int IDX        = 0
) (
    input  wire logic                              i_clk,
    input  wire t_cell_ctl                         i_ctl,
    input  wire logic [INDEX_W-1:0]                i_slot,
    input  wire logic [4*COEF_WIDTH+2*SPK_W-1:0]   i_load_data,
    input  wire logic [4*COEF_WIDTH+2*SPK_W-1:0]   i_next,
    output logic      [4*COEF_WIDTH+2*SPK_W-1:0]   o_entry
);

    logic [4*COEF_WIDTH+2*SPK_W-1:0] r_entry;
    logic                            w_hit;

    // Slots wider than the load index can never be addressed.
    assign w_hit = (IDX < (1 << INDEX_W)) && (i_slot == INDEX_W'(IDX));

    always_ff @(posedge i_clk) begin
        if (i_ctl.load && w_hit) begin
            r_entry <= i_load_data;
        end else if (i_ctl.shift) begin
            r_entry <= i_next;
        end
    end

    assign o_entry = r_entry;

endmodule
`default_nettype wire

### rtl/vbps_sine.sv
// Sine and negated cosine of a turn fraction through one shared
// multiplier, one polynomial step per cycle. Depends on vbps_pkg.
`default_nettype none
module vbps_sine
    import vbps_pkg::*;
#(
    parameter int ANGLE_WIDTH = ANGLE_WIDTH_DEF
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_start,
    input  wire logic [ANGLE_WIDTH-1:0]  i_angle,
    output logic                         o_done,
    output logic signed [XY_W-1:0]       o_x,
    output logic signed [XY_W-1:0]       o_y
);

    localparam logic [ANGLE_WIDTH-1:0] QUARTER = {2'b01, {(ANGLE_WIDTH-2){1'b0}}};

    logic                          r_busy;
    logic                          r_phase;
    logic [1:0]                    r_step;
    logic                          r_done;
    logic [ANGLE_WIDTH-1:0]        r_angle;
    logic [Q15_W-1:0]              r_z2;
    logic [Q15_W-1:0]              r_t;
    logic signed [XY_W-1:0]        r_x;
    logic signed [XY_W-1:0]        r_y;

    logic [ANGLE_WIDTH-1:0]        w_ang;
    logic [14:0]                   w_zs;
    logic [Q15_W-1:0]              w_z;
    logic [Q15_W-1:0]              w_a;
    logic [Q15_W-1:0]              w_b;
    logic [2*Q15_W-1:0]            w_prod;
    logic [2*Q15_W-1:0]            w_sum;
    logic [Q15_W-1:0]              w_rnd;
    logic [Q15_W-1:0]              w_s;
    logic signed [XY_W-1:0]        w_sv;

    // The second pass works on the angle advanced by a quarter turn.
    assign w_ang = r_phase ? (r_angle + QUARTER) : r_angle;

    generate
        if (ANGLE_WIDTH <= 17) begin : g_zup
            assign w_zs = 15'(w_ang[ANGLE_WIDTH-3:0]) << (17 - ANGLE_WIDTH);
        end else begin : g_zdn
            assign w_zs = w_ang[ANGLE_WIDTH-3 -: 15];
        end
    endgenerate

    // Odd quadrants mirror the fraction of the quarter.
    assign w_z = w_ang[ANGLE_WIDTH-2] ? (ONE_Q15 - {2'b00, w_zs}) : {2'b00, w_zs};

    always_comb begin
        case (r_step)
            2'd0: begin
                w_a = w_z;
                w_b = w_z;
            end
            2'd1: begin
                w_a = POLY_C;
                w_b = r_z2;
            end
            2'd2: begin
                w_a = POLY_B - r_t;
                w_b = r_z2;
            end
            2'd3: begin
                w_a = POLY_A - r_t;
                w_b = w_z;
            end
            default: begin
                w_a = '0;
                w_b = '0;
            end
        endcase
    end

    assign w_prod = w_a * w_b;
    assign w_sum  = w_prod + 34'd16384;
    assign w_rnd  = w_sum[31:15];
    assign w_s    = (w_rnd > ONE_Q15) ? ONE_Q15 : w_rnd;
    assign w_sv   = w_ang[ANGLE_WIDTH-1] ? -$signed({1'b0, w_s}) : $signed({1'b0, w_s});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_phase <= 1'b0;
            r_step  <= 2'd0;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy  <= 1'b1;
                r_phase <= 1'b0;
                r_step  <= 2'd0;
            end else if (r_busy) begin
                r_step <= r_step + 2'd1;
                if (r_step == 2'd3) begin
                    r_phase <= 1'b1;
                    if (r_phase) begin
                        r_busy <= 1'b0;
                        r_done <= 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_angle <= i_angle;
        end
        if (r_busy) begin
            case (r_step)
                2'd0: r_z2 <= w_rnd;
                2'd1: r_t  <= w_rnd;
                2'd2: r_t  <= w_rnd;
                2'd3: begin
                    if (r_phase) begin
                        r_y <= -w_sv;
                    end else begin
                        r_x <= w_sv;
                    end
                end
                default: r_t <= r_t;
            endcase
        end
    end

    assign o_done = r_done;
    assign o_x    = r_x;
    assign o_y    = r_y;

endmodule
`default_nettype wire

### rtl/vbps_eval.sv
// Gain pipeline fed from the head of the cell ring: products, gain sums
// with the tolerance test, squares, and the running best pair.
// Depends on vbps_pkg.
`default_nettype none
module vbps_eval
    import vbps_pkg::*;
#(
    parameter int COEF_WIDTH = COEF_WIDTH_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire t_eval_ctl                         i_ctl,
    input  wire logic [4*COEF_WIDTH+2*SPK_W-1:0]   i_entry,
    input  wire logic signed [XY_W-1:0]            i_x,
    input  wire logic signed [XY_W-1:0]            i_y,
    output logic                                   o_found,
    output logic [2*(COEF_WIDTH+16):0]             o_best,
    output logic [COEF_WIDTH+15:0]                 o_u1,
    output logic [COEF_WIDTH+15:0]                 o_u2,
    output logic [SPK_W-1:0]                       o_ch_a,
    output logic [SPK_W-1:0]                       o_ch_b
);

    localparam int PW = COEF_WIDTH + XY_W;
    localparam int GW = PW + 1;
    localparam int UW = COEF_WIDTH + 16;
    localparam int SW = 2 * UW + 1;
    localparam logic signed [GW-1:0] TOL_LO = GW'(-NEG_TOL);

    logic signed [COEF_WIDTH-1:0] w_m0, w_m1, w_m2, w_m3;
    logic signed [PW-1:0]         w_p0, w_p1, w_p2, w_p3;
    logic signed [GW-1:0]         w_g1, w_g2;
    logic [UW-1:0]                w_u1, w_u2;
    logic [2*UW-1:0]              w_sq1, w_sq2;
    logic [SW-1:0]                w_s;

    logic                  r_a_valid, r_b_valid, r_c_valid;
    logic signed [PW-1:0]  r_p0, r_p1, r_p2, r_p3;
    logic [2*SPK_W-1:0]    r_a_spk, r_b_spk, r_c_spk;
    logic [UW-1:0]         r_b_u1, r_b_u2, r_c_u1, r_c_u2;
    logic [2*UW-1:0]       r_sq1, r_sq2;
    logic [SW-1:0]         r_best;
    logic [UW-1:0]         r_u1, r_u2;
    logic [2*SPK_W-1:0]    r_spk;

    assign w_m0 = i_entry[0*COEF_WIDTH +: COEF_WIDTH];
    assign w_m1 = i_entry[1*COEF_WIDTH +: COEF_WIDTH];
    assign w_m2 = i_entry[2*COEF_WIDTH +: COEF_WIDTH];
    assign w_m3 = i_entry[3*COEF_WIDTH +: COEF_WIDTH];

    assign w_p0 = w_m0 * i_x;
    assign w_p1 = w_m1 * i_y;
    assign w_p2 = w_m2 * i_x;
    assign w_p3 = w_m3 * i_y;

    assign w_g1 = GW'(r_p0) + GW'(r_p1);
    assign w_g2 = GW'(r_p2) + GW'(r_p3);
    // Slightly negative gains pass the test but count as zero.
    assign w_u1 = (w_g1 > 0) ? w_g1[UW-1:0] : '0;
    assign w_u2 = (w_g2 > 0) ? w_g2[UW-1:0] : '0;

    assign w_sq1 = r_b_u1 * r_b_u1;
    assign w_sq2 = r_b_u2 * r_b_u2;
    assign w_s   = SW'(r_sq1) + SW'(r_sq2);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.clear) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
            r_best    <= '0;
        end else begin
            r_a_valid <= i_ctl.valid;
            r_b_valid <= r_a_valid && (w_g1 >= TOL_LO) && (w_g2 >= TOL_LO);
            r_c_valid <= r_b_valid;
            if (r_c_valid && (w_s > r_best)) begin
                r_best <= w_s;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_p0    <= w_p0;
        r_p1    <= w_p1;
        r_p2    <= w_p2;
        r_p3    <= w_p3;
        r_a_spk <= i_entry[4*COEF_WIDTH +: 2*SPK_W];
        r_b_u1  <= w_u1;
        r_b_u2  <= w_u2;
        r_b_spk <= r_a_spk;
        r_sq1   <= w_sq1;
        r_sq2   <= w_sq2;
        r_c_u1  <= r_b_u1;
        r_c_u2  <= r_b_u2;
        r_c_spk <= r_b_spk;
        if (r_c_valid && (w_s > r_best)) begin
            r_u1  <= r_c_u1;
            r_u2  <= r_c_u2;
            r_spk <= r_c_spk;
        end
    end

    // Only a strictly positive magnitude can win, so a nonzero best means found.
    assign o_found = (r_best != '0);
    assign o_best  = r_best;
    assign o_u1    = r_u1;
    assign o_u2    = r_u2;
    assign o_ch_a  = r_spk[SPK_W-1:0];
    assign o_ch_b  = r_spk[2*SPK_W-1:SPK_W];

endmodule
`default_nettype wire

### rtl/vbps_norm.sv
// Gain normalizer: a bit-serial integer square root of the winning
// magnitude, then two restoring dividers producing the Q1.15 gains.
// Depends on vbps_pkg.
`default_nettype none
module vbps_norm
    import vbps_pkg::*;
#(
    parameter int COEF_WIDTH = COEF_WIDTH_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    input  wire logic [2*(COEF_WIDTH+16):0]    i_s,
    input  wire logic [COEF_WIDTH+15:0]        i_u1,
    input  wire logic [COEF_WIDTH+15:0]        i_u2,
    output logic                               o_done,
    output logic [GAIN_W-1:0]                  o_g1,
    output logic [GAIN_W-1:0]                  o_g2
);

    localparam int UW     = COEF_WIDTH + 16;
    localparam int SW     = 2 * UW + 1;
    localparam int MW     = UW + 1;
    localparam int NW     = UW + 16;
    localparam int STEP_W = $clog2(MW);

    logic               r_sqrt_busy, r_prep, r_div_busy, r_done;
    logic [STEP_W-1:0]  r_cnt;
    logic [SW-1:0]      r_v, r_res, r_bit;
    logic [MW-1:0]      r_m;
    logic [MW:0]        r_rem1, r_rem2;
    logic [QUOT_W-1:0]  r_n1, r_n2, r_q1, r_q2;
    logic [GAIN_W-1:0]  r_g1, r_g2;

    logic [SW-1:0]      w_trial;
    logic               w_take;
    logic [NW-1:0]      w_num1, w_num2;
    logic [MW:0]        w_t1, w_t2;
    logic               w_b1, w_b2;
    logic [QUOT_W-1:0]  w_q1, w_q2;

    assign w_trial = r_res + r_bit;
    assign w_take  = (r_v >= w_trial);

    // Rounding half up folds in as half the divisor added to the dividend.
    assign w_num1 = {i_u1, 15'd0} + NW'(r_m >> 1);
    assign w_num2 = {i_u2, 15'd0} + NW'(r_m >> 1);

    assign w_t1 = {r_rem1[MW-1:0], r_n1[QUOT_W-1]};
    assign w_t2 = {r_rem2[MW-1:0], r_n2[QUOT_W-1]};
    assign w_b1 = (w_t1 >= {1'b0, r_m});
    assign w_b2 = (w_t2 >= {1'b0, r_m});
    assign w_q1 = {r_q1[QUOT_W-2:0], w_b1};
    assign w_q2 = {r_q2[QUOT_W-2:0], w_b2};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sqrt_busy <= 1'b0;
            r_prep      <= 1'b0;
            r_div_busy  <= 1'b0;
            r_done      <= 1'b0;
            r_cnt       <= '0;
        end else begin
            r_done <= 1'b0;
            r_prep <= 1'b0;
            if (i_start) begin
                r_sqrt_busy <= 1'b1;
                r_cnt       <= STEP_W'(MW - 1);
            end else if (r_sqrt_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_sqrt_busy <= 1'b0;
                    r_prep      <= 1'b1;
                end
            end else if (r_prep) begin
                r_div_busy <= 1'b1;
                r_cnt      <= STEP_W'(QUOT_W - 1);
            end else if (r_div_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_div_busy <= 1'b0;
                    r_done     <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_v   <= i_s;
            r_res <= '0;
            r_bit <= {1'b1, {(SW-1){1'b0}}};
        end else if (r_sqrt_busy) begin
            if (w_take) begin
                r_v   <= r_v - w_trial;
                r_res <= (r_res >> 1) + r_bit;
            end else begin
                r_res <= r_res >> 1;
            end
            r_bit <= r_bit >> 2;
        end
        if (r_sqrt_busy && (r_cnt == '0)) begin
            r_m <= w_take ? MW'((r_res >> 1) + r_bit) : MW'(r_res >> 1);
        end
        if (r_prep) begin
            r_rem1 <= (MW+1)'(w_num1[NW-1:QUOT_W]);
            r_rem2 <= (MW+1)'(w_num2[NW-1:QUOT_W]);
            r_n1   <= w_num1[QUOT_W-1:0];
            r_n2   <= w_num2[QUOT_W-1:0];
            r_q1   <= '0;
            r_q2   <= '0;
        end else if (r_div_busy) begin
            r_rem1 <= w_b1 ? (w_t1 - {1'b0, r_m}) : w_t1;
            r_rem2 <= w_b2 ? (w_t2 - {1'b0, r_m}) : w_t2;
            r_n1   <= r_n1 << 1;
            r_n2   <= r_n2 << 1;
            r_q1   <= w_q1;
            r_q2   <= w_q2;
            if (r_cnt == '0) begin
                r_g1 <= (w_q1 > ONE_Q15) ? GAIN_W'(ONE_Q15) : w_q1[GAIN_W-1:0];
                r_g2 <= (w_q2 > ONE_Q15) ? GAIN_W'(ONE_Q15) : w_q2[GAIN_W-1:0];
            end
        end
    end

    assign o_done = r_done;
    assign o_g1   = r_g1;
    assign o_g2   = r_g2;

endmodule
`default_nettype wire

### rtl/vbap_pair_gain_search.sv
// Two-dimensional amplitude panning over a ring of speaker-pair cells.
// A query runs eight sine steps, one ring rotation, the gain pipeline,
// then, when a pair is found, the square root and two dividers.
// Items are taken one at a time; the result register lets the next item in.
// Reset is synchronous, active low; the pair table holds no reset.
`default_nettype none
`include "vbap_pair_gain_search_defines.svh"
module vbap_pair_gain_search
    import vbps_pkg::*;
#(
    parameter int MAX_PAIRS   = MAX_PAIRS_DEF,
    parameter int COEF_WIDTH  = COEF_WIDTH_DEF,
    parameter int ANGLE_WIDTH = ANGLE_WIDTH_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // Configuration: the pair_count register.
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [PCNT_W-1:0]     i_cfg_data,
    // Input items.
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    // Low to high: entry_index, row0_x, row0_y, row1_x, row1_y,
    // speaker_a, speaker_b, azimuth, zero fill.
    input  wire logic [S_TDATA_W-1:0]  s_axis_tdata,
    // op.
    input  wire logic                  s_axis_tuser,
    // Result items.
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    // Low to high: first_channel, second_channel, first_gain,
    // second_gain, zero fill.
    output logic [M_TDATA_W-1:0]       m_axis_tdata,
    // found.
    output logic                       m_axis_tuser
);

    localparam int UW    = COEF_WIDTH + 16;
    localparam int SW    = 2 * UW + 1;
    localparam int EW    = 4 * COEF_WIDTH + 2 * SPK_W;
    localparam int CNT_W = $clog2(MAX_PAIRS);
    localparam int COEF_HI = (1 << (COEF_WIDTH - 1)) - 1;

    // Coefficients are clamped to COEF_WIDTH signed bits when loaded.
    function automatic logic [COEF_WIDTH-1:0] sat_coef(input logic signed [RAW_COEF_W-1:0] v);
        logic signed [31:0] w;
        w = 32'(v);
        if (w > COEF_HI) begin
            w = COEF_HI;
        end else if (w < -COEF_HI - 1) begin
            w = -COEF_HI - 1;
        end
        return w[COEF_WIDTH-1:0];
    endfunction

    // Input fields.
    logic [INDEX_W-1:0]     w_slot;
    logic [RAW_COEF_W-1:0]  w_r0x, w_r0y, w_r1x, w_r1y;
    logic [SPK_W-1:0]       w_spk_a, w_spk_b;
    logic [AZ_W-1:0]        w_az;
    logic [EW-1:0]          w_load_data;
    logic                   w_in_acc;
    logic                   w_query;

    assign w_slot  = s_axis_tdata[4:0];
    assign w_r0x   = s_axis_tdata[20:5];
    assign w_r0y   = s_axis_tdata[36:21];
    assign w_r1x   = s_axis_tdata[52:37];
    assign w_r1y   = s_axis_tdata[68:53];
    assign w_spk_a = s_axis_tdata[73:69];
    assign w_spk_b = s_axis_tdata[78:74];
    assign w_az    = s_axis_tdata[94:79];

    assign w_load_data = {w_spk_b, w_spk_a, sat_coef(w_r1y), sat_coef(w_r1x),
                          sat_coef(w_r0y), sat_coef(w_r0x)};

    t_state                 r_state;
    logic [PCNT_W-1:0]      r_pair_count;
    logic [CNT_W-1:0]       r_cnt;
    logic [2:0]             r_drain;
    logic                   r_m_valid;
    logic                   r_o_found;
    logic [SPK_W-1:0]       r_o_ch_a, r_o_ch_b;
    logic [GAIN_W-1:0]      r_o_g1, r_o_g2;

    logic [PCNT_W:0]        w_limit;
    logic                   w_out_free;
    logic                   w_sine_start;
    logic                   w_sine_done;
    logic                   w_norm_start;
    logic                   w_norm_done;
    logic signed [XY_W-1:0] w_x, w_y;
    t_cell_ctl              w_cell_ctl;
    t_eval_ctl              w_eval_ctl;
    logic [EW-1:0]          w_entry [MAX_PAIRS];
    logic                   w_found;
    logic [SW-1:0]          w_best;
    logic [UW-1:0]          w_u1, w_u2;
    logic [SPK_W-1:0]       w_ch_a, w_ch_b;
    logic [GAIN_W-1:0]      w_g1, w_g2;

    // Configuration is always taken; the user must write it only while idle, the block does not enforce it.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pair_count <= PCNT_W'(2);
        end else if (i_cfg_valid) begin
            r_pair_count <= i_cfg_data;
        end
    end

    // A count above the table size is held to the table size.
    assign w_limit = ({1'b0, r_pair_count} > (PCNT_W+1)'(MAX_PAIRS)) ?
                     (PCNT_W+1)'(MAX_PAIRS) : {1'b0, r_pair_count};

    assign s_axis_tready = (r_state == ST_IDLE);
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;
    assign w_query       = (t_op'(s_axis_tuser) == OP_QUERY);
    assign w_sine_start  = w_in_acc && w_query;
    assign w_out_free    = !r_m_valid || m_axis_tready;
    assign w_norm_start  = (r_state == ST_DRAIN) && (r_drain == 3'(EVAL_DEPTH - 1)) && w_found;

    // The ring rotates exactly once per query, so each entry ends up back
    // in its own cell; the first pair_count entries reach the pipeline.
    assign w_cell_ctl.load  = w_in_acc && !w_query;
    assign w_cell_ctl.shift = (r_state == ST_SCAN);
    assign w_eval_ctl.clear = w_sine_start;
    assign w_eval_ctl.valid = (r_state == ST_SCAN) &&
                              ((PCNT_W+1)'(r_cnt) < w_limit);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
            r_drain <= '0;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (w_sine_start) begin
                        r_state <= ST_SINE;
                    end
                end
                ST_SINE: begin
                    if (w_sine_done) begin
                        r_state <= ST_SCAN;
                        r_cnt   <= '0;
                    end
                end
                ST_SCAN: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == CNT_W'(MAX_PAIRS - 1)) begin
                        r_state <= ST_DRAIN;
                        r_drain <= '0;
                    end
                end
                ST_DRAIN: begin
                    r_drain <= r_drain + 3'd1;
                    if (r_drain == 3'(EVAL_DEPTH - 1)) begin
                        r_state <= w_found ? ST_NORM : ST_FIN;
                    end
                end
                ST_NORM: begin
                    if (w_norm_done) begin
                        r_state <= ST_FIN;
                    end
                end
                ST_FIN: begin
                    if (w_out_free) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // Result register: a finished result waits here while the next item enters.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if ((r_state == ST_FIN) && w_out_free) begin
            r_m_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == ST_FIN) && w_out_free) begin
            r_o_found <= w_found;
            r_o_ch_a  <= w_found ? w_ch_a : '0;
            r_o_ch_b  <= w_found ? w_ch_b : '0;
            r_o_g1    <= w_found ? w_g1 : '0;
            r_o_g2    <= w_found ? w_g2 : '0;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tuser  = r_o_found;
    assign m_axis_tdata  = {6'd0, r_o_g2, r_o_g1, r_o_ch_b, r_o_ch_a};

    vbps_sine #(
        .ANGLE_WIDTH (ANGLE_WIDTH)
    ) u_sine (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_sine_start),
        .i_angle (ANGLE_WIDTH'(w_az)),
        .o_done  (w_sine_done),
        .o_x     (w_x),
        .o_y     (w_y)
    );

    // Cell i hands its entry to cell i-1; cell 0 wraps to the last cell.
    for (genvar i = 0; i < MAX_PAIRS; i++) begin : g_cell
        vbps_cell #(
            .COEF_WIDTH (COEF_WIDTH),
            .IDX        (i)
        ) u_cell (
            .i_clk       (i_clk),
            .i_ctl       (w_cell_ctl),
            .i_slot      (w_slot),
            .i_load_data (w_load_data),
            .i_next      (w_entry[(i + 1) % MAX_PAIRS]),
            .o_entry     (w_entry[i])
        );
    end

    vbps_eval #(
        .COEF_WIDTH (COEF_WIDTH)
    ) u_eval (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_eval_ctl),
        .i_entry (w_entry[0]),
        .i_x     (w_x),
        .i_y     (w_y),
        .o_found (w_found),
        .o_best  (w_best),
        .o_u1    (w_u1),
        .o_u2    (w_u2),
        .o_ch_a  (w_ch_a),
        .o_ch_b  (w_ch_b)
    );

    vbps_norm #(
        .COEF_WIDTH (COEF_WIDTH)
    ) u_norm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_norm_start),
        .i_s     (w_best),
        .i_u1    (w_u1),
        .i_u2    (w_u2),
        .o_done  (w_norm_done),
        .o_g1    (w_g1),
        .o_g2    (w_g2)
    );

    `VBPS_ASSERT_IMP(a_sine_done_in_sine, i_clk, i_rst_n, w_sine_done, r_state == ST_SINE, "sine finished outside its state")
    `VBPS_ASSERT_NXT(a_scan_one_turn, i_clk, i_rst_n, (r_state == ST_SCAN) && (r_cnt == CNT_W'(MAX_PAIRS - 1)), r_state == ST_DRAIN, "ring rotation did not end after one turn")
    `VBPS_ASSERT_IMP(a_not_found_zero, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tuser, m_axis_tdata == '0, "result without a winner carries data")
    `VBPS_ASSERT_IMP(a_norm_done_in_norm, i_clk, i_rst_n, w_norm_done, r_state == ST_NORM, "normalizer finished outside its state")

endmodule
`default_nettype wire

### test/tb_vbap_pair_gain_search.sv
// Self-checking testbench for the 2-D amplitude panning pair search block.
// Depends on vbps_pkg and the vbap_pair_gain_search RTL; drives a directed
// table of loads, queries and pair_count writes, then random phases.
`timescale 1ns / 1ps
module tb_vbap_pair_gain_search;
    import vbps_pkg::*;

    localparam int N_SLOTS     = 32;
    localparam int SETTLE_CYC  = 160;   // idle wait after the last result is taken
    localparam int HOLD_CYC    = 400;   // long receiver hold-off
    localparam int RAND_ITEMS  = 830;

    // Kinds of rows in the directed table.
    typedef enum logic [1:0] {
        ROW_ITEM,
        ROW_CFG
    } t_row_kind;

    // One pan result as the block reports it.
    typedef struct {
        logic        found;
        logic [4:0]  ch_a;
        logic [4:0]  ch_b;
        logic [15:0] gain_a;
        logic [15:0] gain_b;
    } t_pan;

    // One input item.
    typedef struct {
        t_op                op;
        logic [4:0]         slot;
        logic signed [15:0] coef [4];
        logic [4:0]         spk_a;
        logic [4:0]         spk_b;
        logic [15:0]        az;
    } t_item;

    // One row of the directed table. A typed result is used where known is set.
    typedef struct {
        t_row_kind  kind;
        t_item      item;
        logic [5:0] count;
        logic       known;
        t_pan       res;
    } t_row;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [PCNT_W-1:0]    i_cfg_data = '0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata = '0;
    logic                 s_axis_tuser = 1'b0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_axis_tdata;
    logic                 m_axis_tuser;

    vbap_pair_gain_search dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #1 i_clk = ~i_clk;

    // The run is cut off here if the block hangs.
    initial begin
        #4_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    // Shadow copy of the block's table and register.
    longint     coef_tbl [N_SLOTS][4];
    logic [4:0] spk_tbl  [N_SLOTS][2];
    int         pair_cnt = 2;

    t_pan pending_pans [$];
    int   n_errors  = 0;
    int   n_items   = 0;
    int   n_queries = 0;
    int   n_found   = 0;
    int   n_cfg     = 0;

    // Receiver controls: a hold-off counter and a switch for no idling.
    int   hold_left = 0;
    bit   steady    = 1'b0;

    task automatic report(input string what, input longint got, input longint want);
        n_errors++;
        $display("mismatch %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
    endtask

    // Sine of a 16-bit turn fraction in Q1.15, built from the quarter-wave polynomial.
    function automatic longint turn_sin(input int unsigned a);
        int unsigned q;
        longint      z, z2, t;
        a  = a & 32'hFFFF;
        q  = (a >> 14) & 3;
        z  = longint'(a & 32'h3FFF) << 1;
        if (q[0]) begin
            z = 32768 - z;
        end
        z2 = (z * z + 16384) >>> 15;
        t  = (longint'(POLY_C) * z2 + 16384) >>> 15;
        t  = longint'(POLY_B) - t;
        t  = (t * z2 + 16384) >>> 15;
        t  = longint'(POLY_A) - t;
        t  = (t * z + 16384) >>> 15;
        if (t > 32768) begin
            t = 32768;
        end
        return q[1] ? -t : t;
    endfunction

    function automatic longint unsigned root_floor(input longint unsigned v);
        longint unsigned res, bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v   = v - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic longint unsigned unit_gain(input longint unsigned g,
                                                  input longint unsigned mag);
        longint unsigned q;
        q = (g * 32768 + (mag >> 1)) / mag;
        return (q > 32768) ? 32768 : q;
    endfunction

    // Walks the configured pairs and picks the loudest one with neither gain below -NEG_TOL.
    function automatic t_pan pan_search(input logic [15:0] az);
        t_pan            r;
        longint          x, y, g1, g2;
        longint unsigned u1, u2, s, best, mag;
        int              n;
        r    = '{default: '0};
        best = 0;
        x    = turn_sin(az);
        y    = -turn_sin(az + 16384);
        n    = (pair_cnt > N_SLOTS) ? N_SLOTS : pair_cnt;
        for (int i = 0; i < n; i++) begin
            g1 = coef_tbl[i][0] * x + coef_tbl[i][1] * y;
            g2 = coef_tbl[i][2] * x + coef_tbl[i][3] * y;
            if (g1 < -NEG_TOL || g2 < -NEG_TOL) continue;
            u1 = (g1 > 0) ? longint'(unsigned'(g1)) : 0;
            u2 = (g2 > 0) ? longint'(unsigned'(g2)) : 0;
            s  = u1 * u1 + u2 * u2;
            if (s > best) begin
                mag      = root_floor(s);
                best     = s;
                r.found  = 1'b1;
                r.ch_a   = spk_tbl[i][0];
                r.ch_b   = spk_tbl[i][1];
                r.gain_a = 16'(unit_gain(u1, mag));
                r.gain_b = 16'(unit_gain(u2, mag));
            end
        end
        return r;
    endfunction

    function automatic int gap_len();
        int p;
        p = $urandom_range(99);
        if (steady || p < 60) return 0;
        if (p < 92) return $urandom_range(3, 1);
        return $urandom_range(40, 10);
    endfunction

    // Offers one item, waits for it to be taken and records what it should cause.
    task automatic send_item(input t_item it, input bit known, input t_pan typed);
        int   gap;
        t_pan want_pan;
        gap = gap_len();
        @(negedge i_clk);
        if (gap > 0) begin
            s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tuser  = it.op;
        s_axis_tdata  = {1'b0, it.az, it.spk_b, it.spk_a, it.coef[3], it.coef[2],
                         it.coef[1], it.coef[0], it.slot};
        do @(posedge i_clk); while (!s_axis_tready);
        n_items++;
        if (it.op == OP_LOAD) begin
            for (int k = 0; k < 4; k++) coef_tbl[it.slot][k] = it.coef[k];
            spk_tbl[it.slot][0] = it.spk_a;
            spk_tbl[it.slot][1] = it.spk_b;
        end else begin
            n_queries++;
            want_pan     = known ? typed : pan_search(it.az);
            pending_pans = {pending_pans, want_pan};
        end
    endtask

    // Stops offering, lets every result arrive and the block settle.
    task automatic drain();
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        while (pending_pans.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYC) @(negedge i_clk);
    endtask

    task automatic write_count(input logic [5:0] val);
        drain();
        i_cfg_valid = 1'b1;
        i_cfg_data  = val;
        do @(posedge i_clk); while (!o_cfg_ready);
        pair_cnt = val;
        n_cfg++;
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    function automatic logic signed [15:0] rand_coef();
        int p;
        p = $urandom_range(99);
        if (p < 8)  return 16'sh7FFF;
        if (p < 16) return 16'sh8000;
        if (p < 22) return '0;
        if (p < 60) return 16'($urandom_range(16383) - 8192);
        return 16'($urandom);
    endfunction

    function automatic t_item rand_item(input t_op op);
        t_item it;
        it.op    = op;
        it.slot  = 5'($urandom_range(31));
        for (int k = 0; k < 4; k++) it.coef[k] = rand_coef();
        it.spk_a = 5'($urandom_range(31));
        it.spk_b = 5'($urandom_range(31));
        it.az    = 16'($urandom);
        return it;
    endfunction

    function automatic t_item mk(input t_op op, input logic [4:0] slot,
                                 input int c0, input int c1, input int c2, input int c3,
                                 input logic [4:0] sa, input logic [4:0] sb,
                                 input logic [15:0] az);
        t_item it;
        it.op    = op;
        it.slot  = slot;
        it.coef  = '{16'(c0), 16'(c1), 16'(c2), 16'(c3)};
        it.spk_a = sa;
        it.spk_b = sb;
        it.az    = az;
        return it;
    endfunction

    // Receiver: random ready at the falling edge, long hold-offs on request.
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else if (steady) begin
            m_axis_tready <= 1'b1;
        end else begin
            m_axis_tready <= ($urandom_range(99) < 70);
        end
    end

    // Result checker: every accepted result is matched against the oldest expectation.
    always @(posedge i_clk) begin
        t_pan want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_pans.size() == 0) begin
                report("unexpected result", longint'(m_axis_tuser), -1);
            end else begin
                want = pending_pans.pop_front();
                if (want.found) n_found++;
                if (m_axis_tuser !== want.found)
                    report("found", longint'(m_axis_tuser), longint'(want.found));
                if (m_axis_tdata[4:0] !== want.ch_a)
                    report("first_channel", longint'(m_axis_tdata[4:0]),
                           longint'(want.ch_a));
                if (m_axis_tdata[9:5] !== want.ch_b)
                    report("second_channel", longint'(m_axis_tdata[9:5]),
                           longint'(want.ch_b));
                if (m_axis_tdata[25:10] !== want.gain_a)
                    report("first_gain", longint'(m_axis_tdata[25:10]),
                           longint'(want.gain_a));
                if (m_axis_tdata[41:26] !== want.gain_b)
                    report("second_gain", longint'(m_axis_tdata[41:26]),
                           longint'(want.gain_b));
            end
        end
    end

    t_row dir_rows [$];

    task automatic add_item(input t_item it);
        t_row r;
        r.kind   = ROW_ITEM;
        r.item   = it;
        r.count  = '0;
        r.known  = 1'b0;
        r.res    = '{default: '0};
        dir_rows = {dir_rows, r};
    endtask

    task automatic add_typed(input t_item it, input t_pan res);
        t_row r;
        r.kind   = ROW_ITEM;
        r.item   = it;
        r.count  = '0;
        r.known  = 1'b1;
        r.res    = res;
        dir_rows = {dir_rows, r};
    endtask

    task automatic add_cfg(input logic [5:0] val);
        t_row r;
        r.kind   = ROW_CFG;
        r.item   = mk(OP_LOAD, 0, 0, 0, 0, 0, 0, 0, 16'd0);
        r.count  = val;
        r.known  = 1'b0;
        r.res    = '{default: '0};
        dir_rows = {dir_rows, r};
    endtask

    initial begin
        t_pan   none;
        t_item  it;
        int     left;
        int     phase;
        logic [5:0] cnt;

        none = '{default: '0};
        for (int i = 0; i < N_SLOTS; i++) begin
            coef_tbl[i] = '{0, 0, 0, 0};
            spk_tbl[i]  = '{5'd0, 5'd0};
        end

        // Directed table. After reset two pairs are visited, so slots 0 and 1
        // are written before the first query and later queries stay below them.
        add_item(mk(OP_LOAD, 0, 4096, 0, 0, -4096, 3, 7, 0));
        add_item(mk(OP_LOAD, 1, 0, 0, 0, 0, 1, 2, 0));        // zero magnitude
        add_typed(mk(OP_QUERY, 0, 0, 0, 0, 0, 0, 0, 16'd0),
                  '{1'b1, 5'd3, 5'd7, 16'd0, 16'd32768});
        add_typed(mk(OP_QUERY, 0, 0, 0, 0, 0, 0, 0, 16'd16384),
                  '{1'b1, 5'd3, 5'd7, 16'd32768, 16'd0});
        add_typed(mk(OP_QUERY, 0, 0, 0, 0, 0, 0, 0, 16'd32768), none);
        add_item(mk(OP_QUERY, 0, 0, 0, 0, 0, 0, 0, 16'd49152));
        add_item(mk(OP_QUERY, 0, 0, 0, 0, 0, 0, 0, 16'hFFFF));
        add_cfg(6'd0);                                        // no pair visited
        add_typed(mk(OP_QUERY, 0, 0, 0, 0, 0, 0, 0, 16'd1000), none);
        add_cfg(6'd1);
        add_item(mk(OP_QUERY, 0, 0, 0, 0, 0, 0, 0, 16'd8192));
        add_item(mk(OP_LOAD, 1, 32767, -32768, -32768, 32767, 31, 0, 0));
        add_cfg(6'd2);
        add_item(mk(OP_QUERY, 0, 0, 0, 0, 0, 0, 0, 16'd0));
        add_item(mk(OP_QUERY, 0, 0, 0, 0, 0, 0, 0, 16'd20000));
        add_item(mk(OP_QUERY, 0, 0, 0, 0, 0, 0, 0, 16'd40000));
        add_item(mk(OP_QUERY, 0, 0, 0, 0, 0, 0, 0, 16'd60000));
        add_item(mk(OP_LOAD, 0, -32768, 32767, 32767, -32768, 0, 31, 0));
        add_item(mk(OP_QUERY, 0, 0, 0, 0, 0, 0, 0, 16'd12345));
        add_item(mk(OP_QUERY, 0, 0, 0, 0, 0, 0, 0, 16'd54321));
        add_item(mk(OP_LOAD, 31, 1, -1, -1, 1, 31, 31, 0));

        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (dir_rows[i]) begin
            if (dir_rows[i].kind == ROW_CFG) begin
                write_count(dir_rows[i].count);
            end else begin
                send_item(dir_rows[i].item, dir_rows[i].known, dir_rows[i].res);
            end
        end

        // Fill every slot so that any pair count reads only written entries.
        for (int i = 0; i < N_SLOTS; i++) begin
            it      = rand_item(OP_LOAD);
            it.slot = 5'(i);
            send_item(it, 1'b0, none);
        end
        left = RAND_ITEMS - N_SLOTS;

        // Random phases, each opened by a register write on an idle block.
        phase = 0;
        while (left > 0) begin
            case (phase % 6)
                0: cnt = 6'd63;                               // saturates to the table size
                1: cnt = 6'd32;
                2: cnt = 6'd2;
                3: cnt = 6'($urandom_range(32, 3));
                4: cnt = 6'($urandom_range(63));
                default: cnt = 6'($urandom_range(1));
            endcase
            write_count(cnt);
            steady = (phase % 5 == 4);
            if (phase % 4 == 1) hold_left = HOLD_CYC;         // back pressure fills the block
            for (int k = 0; k < 50 && left > 0; k++) begin
                send_item(rand_item(($urandom_range(99) < 70) ? OP_QUERY : OP_LOAD),
                          1'b0, none);
                left--;
            end
            steady = 1'b0;
            phase++;
        end

        drain();
        $display("Ran %0d items (%0d pan queries, %0d with a winning pair), %0d count writes.",
                 n_items, n_queries, n_found, n_cfg);
        $display("Mismatches seen: %0d", n_errors);
        if (n_errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
